// ===== rtl/core/radar_presence_frame_parser_macros.svh =====
// Assertion macros shared by the radar frame parser RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef RADAR_PRESENCE_FRAME_PARSER_MACROS_SVH
`define RADAR_PRESENCE_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RPFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpfp check failed");

// Next-cycle implication, checked outside reset.
`define RPFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpfp check failed");

`endif

// ===== rtl/core/rpfp_pkg.sv =====
// Shared types and constants for the radar presence frame parser.
// No dependencies; used by rpfp_parser and the top level.
package rpfp_pkg;

    localparam logic [7:0] HDR_B1 = 8'hF4;
    localparam logic [7:0] HDR_B2 = 8'hF3;
    localparam logic [7:0] HDR_B3 = 8'hF2;
    localparam logic [7:0] HDR_B4 = 8'hF1;
    localparam logic [7:0] FTR_B1 = 8'hF8;
    localparam logic [7:0] FTR_B2 = 8'hF7;
    localparam logic [7:0] FTR_B3 = 8'hF6;
    localparam logic [7:0] FTR_B4 = 8'hF5;

    localparam int IDX_W = 7;
    localparam int LIMIT_W = 6;
    localparam logic [IDX_W-1:0] IDX_SATURATE = 7'd64;
    localparam logic [LIMIT_W-1:0] OVF_LIMIT_RESET = 6'd60;

    // payload indices that get captured
    localparam logic [IDX_W-1:0] IDX_TARGET = 7'd4;
    localparam logic [IDX_W-1:0] IDX_MOV_ENERGY = 7'd7;
    localparam logic [IDX_W-1:0] IDX_STAT_ENERGY = 7'd10;
    localparam logic [IDX_W-1:0] IDX_DIST_LO = 7'd11;
    localparam logic [IDX_W-1:0] IDX_DIST_HI = 7'd12;

    localparam int OUT_W = 48;

    typedef enum logic [2:0] {
        PH_HDR1,
        PH_HDR2,
        PH_HDR3,
        PH_HDR4,
        PH_BODY,
        PH_FT1,
        PH_FT2,
        PH_FT3
    } phase_t;

    typedef struct packed {
        logic [15:0] distance;
        logic [7:0]  static_energy;
        logic [7:0]  moving_energy;
        logic        stationary;
        logic        moving;
        logic        presence;
        logic [7:0]  target_state;
    } result_t;

endpackage

// ===== rtl/core/rpfp_parser.sv =====
// Frame parser core: header hunt, payload count, captures and footer check.
// Depends on rpfp_pkg and radar_presence_frame_parser_macros.svh.
`include "radar_presence_frame_parser_macros.svh"

module rpfp_parser
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [7:0]                    data_byte,
    input  logic [rpfp_pkg::LIMIT_W-1:0]  overflow_limit,
    output logic                          res_valid,
    output rpfp_pkg::result_t             res
);

    rpfp_pkg::phase_t phase_reg, phase_next;
    logic [rpfp_pkg::IDX_W-1:0] idx_reg, idx_next, idx_inc;
    logic [7:0] tgt_reg, tgt_next;
    logic [7:0] mov_reg, mov_next;
    logic [7:0] stat_reg, stat_next;
    logic [7:0] dlo_reg, dlo_next;
    logic [7:0] dhi_reg, dhi_next;
    logic take;
    logic over;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rpfp_pkg::PH_HDR1;
            idx_reg   <= '0;
            tgt_reg   <= '0;
            mov_reg   <= '0;
            stat_reg  <= '0;
            dlo_reg   <= '0;
            dhi_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            tgt_reg   <= tgt_next;
            mov_reg   <= mov_next;
            stat_reg  <= stat_next;
            dlo_reg   <= dlo_next;
            dhi_reg   <= dhi_next;
        end
    end

    // index after counting this byte, saturating
    assign idx_inc = (idx_reg < rpfp_pkg::IDX_SATURATE) ? idx_reg + 7'd1 : idx_reg;
    assign over = (idx_inc >= {1'b0, overflow_limit});

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        take       = 1'b0;
        res_valid  = 1'b0;
        case (phase_reg)
            rpfp_pkg::PH_HDR1:
            begin
                if (data_byte == rpfp_pkg::HDR_B1)
                    phase_next = rpfp_pkg::PH_HDR2;
            end
            rpfp_pkg::PH_HDR2:
            begin
                phase_next = (data_byte == rpfp_pkg::HDR_B2) ? rpfp_pkg::PH_HDR3
                                                              : rpfp_pkg::PH_HDR1;
            end
            rpfp_pkg::PH_HDR3:
            begin
                phase_next = (data_byte == rpfp_pkg::HDR_B3) ? rpfp_pkg::PH_HDR4
                                                              : rpfp_pkg::PH_HDR1;
            end
            rpfp_pkg::PH_HDR4:
            begin
                if (data_byte == rpfp_pkg::HDR_B4)
                begin
                    phase_next = rpfp_pkg::PH_BODY;
                    idx_next   = '0;
                end
                else
                    phase_next = rpfp_pkg::PH_HDR1;
            end
            rpfp_pkg::PH_BODY:
            begin
                take     = 1'b1;
                idx_next = idx_inc;
                if (data_byte == rpfp_pkg::FTR_B1)
                    phase_next = rpfp_pkg::PH_FT1;
                else if (over)
                    phase_next = rpfp_pkg::PH_HDR1;
            end
            rpfp_pkg::PH_FT1:
            begin
                take       = 1'b1;
                idx_next   = idx_inc;
                phase_next = (data_byte == rpfp_pkg::FTR_B2) ? rpfp_pkg::PH_FT2
                                                              : rpfp_pkg::PH_BODY;
            end
            rpfp_pkg::PH_FT2:
            begin
                take       = 1'b1;
                idx_next   = idx_inc;
                phase_next = (data_byte == rpfp_pkg::FTR_B3) ? rpfp_pkg::PH_FT3
                                                              : rpfp_pkg::PH_BODY;
            end
            rpfp_pkg::PH_FT3:
            begin
                take     = 1'b1;
                idx_next = idx_inc;
                if (data_byte == rpfp_pkg::FTR_B4)
                begin
                    res_valid  = step;
                    phase_next = rpfp_pkg::PH_HDR1;
                end
                else
                    phase_next = rpfp_pkg::PH_BODY;
            end
            default:
            begin
                phase_next = rpfp_pkg::PH_HDR1;
            end
        endcase
    end

    // captures keep their value across frames
    always_comb
    begin
        tgt_next  = tgt_reg;
        mov_next  = mov_reg;
        stat_next = stat_reg;
        dlo_next  = dlo_reg;
        dhi_next  = dhi_reg;
        if (take)
        begin
            case (idx_reg)
                rpfp_pkg::IDX_TARGET:      tgt_next  = data_byte;
                rpfp_pkg::IDX_MOV_ENERGY:  mov_next  = data_byte;
                rpfp_pkg::IDX_STAT_ENERGY: stat_next = data_byte;
                rpfp_pkg::IDX_DIST_LO:     dlo_next  = data_byte;
                rpfp_pkg::IDX_DIST_HI:     dhi_next  = data_byte;
                default: ;
            endcase
        end
    end

    // result includes the final footer byte's own capture
    always_comb
    begin
        res.target_state  = tgt_next;
        res.presence      = (tgt_next != 8'd0);
        res.moving        = (tgt_next inside {8'd1, 8'd3});
        res.stationary    = (tgt_next inside {8'd2, 8'd3});
        res.moving_energy = mov_next;
        res.static_energy = stat_next;
        res.distance      = {dhi_next, dlo_next};
    end

    `RPFP_ASSERT_NOW(a_idx_saturates, clk, rst_n, 1'b1, idx_reg <= rpfp_pkg::IDX_SATURATE)
    `RPFP_ASSERT_NOW(a_result_on_footer, clk, rst_n, res_valid,
        step && phase_reg == rpfp_pkg::PH_FT3 && data_byte == rpfp_pkg::FTR_B4)
    `RPFP_ASSERT_NEXT(a_header_clears_idx, clk, rst_n,
        step && phase_reg == rpfp_pkg::PH_HDR4 && data_byte == rpfp_pkg::HDR_B4,
        idx_reg == '0 && phase_reg == rpfp_pkg::PH_BODY)

endmodule

// ===== rtl/core/radar_presence_frame_parser.sv =====
// Radar presence frame parser, top level: input register, parser core, result register.
// Depends on rpfp_pkg and rpfp_parser.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one received serial byte per item.
//   m_tvalid/m_tready/m_tdata carry one result item per complete frame
//   (header F4 F3 F2 F1, payload, footer F8 F7 F6 F5).
//   cfg_valid/cfg_ready/cfg_data write overflow_limit; cfg_ready is always high.
//   Write it only while no frame byte is in flight.
// Timing:
//   One item accepted per cycle, sustained while the result side does not stall.
//   A byte is held in the input register and parsed in a single pass; the
//   result register then loads from the parser, so m_tvalid rises from the
//   result register after the final footer byte leaves the input register.
// Stalls:
//   While m_tready is low with a result held, the input register holds its
//   byte and s_tready drops once it is full; nothing is dropped.
// Reset:
//   rst_n clears the parser to header hunt, index and captures to zero,
//   overflow_limit to 60, and both registers to empty.

module radar_presence_frame_parser
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] data_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [7:0] target_state, [8] presence, [9] moving, [10] stationary,
    // [18:11] moving_energy, [26:19] static_energy, [42:27] distance, rest zero
    output logic [rpfp_pkg::OUT_W-1:0]   m_tdata,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rpfp_pkg::LIMIT_W-1:0] cfg_data   // overflow_limit
);

    logic                         in_valid_reg;
    logic [7:0]                   in_byte_reg;
    logic                         out_valid_reg;
    rpfp_pkg::result_t            out_reg;
    logic [rpfp_pkg::LIMIT_W-1:0] limit_reg;
    logic                         advance;
    logic                         step;
    logic                         res_valid;
    rpfp_pkg::result_t            res;

    assign advance   = !out_valid_reg || m_tready;
    assign step      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= rpfp_pkg::OVF_LIMIT_RESET;
        else if (cfg_valid)
            limit_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_byte_reg <= s_tdata;
    end

    rpfp_parser u_parser
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .data_byte      (in_byte_reg),
        .overflow_limit (limit_reg),
        .res_valid      (res_valid),
        .res            (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(rpfp_pkg::OUT_W - $bits(rpfp_pkg::result_t)){1'b0}}, out_reg};

endmodule

// ===== dv/tb.sv =====
// Testbench for radar_presence_frame_parser: byte streams with directed and random frames.
// It predicts each result from its own frame tracker and checks results in order.
// Depends on rpfp_pkg and the RTL under rtl/core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RES_W = $bits(rpfp_pkg::result_t);
    localparam int LIM_W = rpfp_pkg::LIMIT_W;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [7:0]                        s_tdata = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [rpfp_pkg::OUT_W-1:0]        m_tdata;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [LIM_W-1:0]                  cfg_data = '0;

    // frame tracker state
    rpfp_pkg::phase_t                  phase_q = rpfp_pkg::PH_HDR1;
    logic [rpfp_pkg::IDX_W-1:0]        index_q = '0;
    logic [7:0]                        grab_q [5] = '{default: 8'h00};
    logic [LIM_W-1:0]                  limit_q = rpfp_pkg::OVF_LIMIT_RESET;
    rpfp_pkg::result_t                 reports_due [$];

    int unsigned errors = 0;
    int unsigned bytes_sent = 0;
    int unsigned burst_left = 0;
    bit          steady = 1'b0;
    int unsigned hold_asks = 0;
    int unsigned hold_done = 0;
    int unsigned hold_left = 0;
    int unsigned rx_cycle = 0;

    radar_presence_frame_parser u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------- prediction

    task automatic count_byte(input logic [7:0] b);
        case (index_q)
            rpfp_pkg::IDX_TARGET:      grab_q[0] = b;
            rpfp_pkg::IDX_MOV_ENERGY:  grab_q[1] = b;
            rpfp_pkg::IDX_STAT_ENERGY: grab_q[2] = b;
            rpfp_pkg::IDX_DIST_LO:     grab_q[3] = b;
            rpfp_pkg::IDX_DIST_HI:     grab_q[4] = b;
            default: ;
        endcase
        if (index_q < rpfp_pkg::IDX_SATURATE)
            index_q = index_q + 1'b1;
    endtask

    task automatic track_byte(input logic [7:0] b);
        rpfp_pkg::result_t r;
        case (phase_q)
            rpfp_pkg::PH_HDR1:
                if (b == rpfp_pkg::HDR_B1)
                    phase_q = rpfp_pkg::PH_HDR2;
            rpfp_pkg::PH_HDR2:
                phase_q = (b == rpfp_pkg::HDR_B2) ? rpfp_pkg::PH_HDR3 : rpfp_pkg::PH_HDR1;
            rpfp_pkg::PH_HDR3:
                phase_q = (b == rpfp_pkg::HDR_B3) ? rpfp_pkg::PH_HDR4 : rpfp_pkg::PH_HDR1;
            rpfp_pkg::PH_HDR4:
            begin
                if (b == rpfp_pkg::HDR_B4)
                begin
                    phase_q = rpfp_pkg::PH_BODY;
                    index_q = '0;
                end
                else
                    phase_q = rpfp_pkg::PH_HDR1;
            end
            rpfp_pkg::PH_BODY:
            begin
                count_byte(b);
                if (index_q >= {1'b0, limit_q})
                    phase_q = rpfp_pkg::PH_HDR1;
                if (b == rpfp_pkg::FTR_B1)
                    phase_q = rpfp_pkg::PH_FT1;
            end
            rpfp_pkg::PH_FT1:
            begin
                count_byte(b);
                phase_q = (b == rpfp_pkg::FTR_B2) ? rpfp_pkg::PH_FT2 : rpfp_pkg::PH_BODY;
            end
            rpfp_pkg::PH_FT2:
            begin
                count_byte(b);
                phase_q = (b == rpfp_pkg::FTR_B3) ? rpfp_pkg::PH_FT3 : rpfp_pkg::PH_BODY;
            end
            default:
            begin
                // last footer byte is captured before the report is built
                count_byte(b);
                if (b == rpfp_pkg::FTR_B4)
                begin
                    r.target_state  = grab_q[0];
                    r.presence      = (grab_q[0] != 8'd0);
                    r.moving        = (grab_q[0] == 8'd1) || (grab_q[0] == 8'd3);
                    r.stationary    = (grab_q[0] == 8'd2) || (grab_q[0] == 8'd3);
                    r.moving_energy = grab_q[1];
                    r.static_energy = grab_q[2];
                    r.distance      = {grab_q[4], grab_q[3]};
                    reports_due.push_back(r);
                    phase_q = rpfp_pkg::PH_HDR1;
                end
                else
                    phase_q = rpfp_pkg::PH_BODY;
            end
        endcase
    endtask

    // ---------------------------------------------------------------- checking

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        rpfp_pkg::result_t got;
        rpfp_pkg::result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                limit_q = cfg_data;
            if (s_tvalid && s_tready)
                track_byte(s_tdata);
            if (m_tvalid && m_tready)
            begin
                got = rpfp_pkg::result_t'(m_tdata[RES_W-1:0]);
                if (reports_due.size() == 0)
                begin
                    $error("result %0h with none expected", m_tdata);
                    errors++;
                end
                else
                begin
                    want = reports_due.pop_front();
                    check_field("target_state", want.target_state, got.target_state);
                    check_field("presence", want.presence, got.presence);
                    check_field("moving", want.moving, got.moving);
                    check_field("stationary", want.stationary, got.stationary);
                    check_field("moving_energy", want.moving_energy, got.moving_energy);
                    check_field("static_energy", want.static_energy, got.static_energy);
                    check_field("distance", want.distance, got.distance);
                    check_field("tdata_pad", '0, m_tdata[rpfp_pkg::OUT_W-1:RES_W]);
                end
            end
        end
    end

    // ---------------------------------------------------------------- result side stalls

    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (hold_done != hold_asks)
        begin
            // long hold-off so the block fills and stalls its input
            hold_done <= hold_asks;
            hold_left <= 400;
            m_tready <= 1'b0;
        end
        else
            case ((rx_cycle / 97) % 4)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 1) == 0);
                2:       m_tready <= ($urandom_range(0, 9) == 0);
                default: m_tready <= (rx_cycle % 3 == 0);
            endcase
    end

    // ---------------------------------------------------------------- stimulus helpers

    // Returns at the edge that accepts the item; the caller either sends the next
    // one in the same step or lowers s_tvalid.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = steady ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= b;
        bytes_sent++;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic logic [7:0] payload_pick();
        case ($urandom_range(0, 9))
            0, 1, 2: return 8'($urandom_range(0, 3));
            3:       return 8'hFF;
            4:       return 8'h00;
            5:       return 8'($urandom_range(8'hF0, 8'hFF));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_noise(input int unsigned n);
        repeat (n)
            send_byte(($urandom_range(0, 3) == 0) ? rpfp_pkg::HDR_B1 : 8'($urandom));
    endtask

    // clean: no deliberate damage; f8_fill: body made only of F8 bytes
    task automatic send_frame(input int unsigned body_len, input bit clean, input bit f8_fill);
        logic [7:0]  hdr [4];
        logic [7:0]  ftr [4];
        int unsigned cut;
        hdr = '{rpfp_pkg::HDR_B1, rpfp_pkg::HDR_B2, rpfp_pkg::HDR_B3, rpfp_pkg::HDR_B4};
        ftr = '{rpfp_pkg::FTR_B1, rpfp_pkg::FTR_B2, rpfp_pkg::FTR_B3, rpfp_pkg::FTR_B4};
        if (!clean && $urandom_range(0, 3) == 0)
            hdr[$urandom_range(1, 3)] = ($urandom_range(0, 1) == 0) ? rpfp_pkg::HDR_B1
                                                                    : 8'($urandom);
        foreach (hdr[i])
            send_byte(hdr[i]);
        for (int i = 0; i < body_len; i++)
        begin
            if (!clean && $urandom_range(0, 15) == 0)
            begin
                // false footer start, broken by the next byte
                cut = $urandom_range(1, 3);
                for (int k = 0; k < cut; k++)
                    send_byte(ftr[k]);
            end
            send_byte(f8_fill ? rpfp_pkg::FTR_B1 : payload_pick());
        end
        if (!clean && $urandom_range(0, 5) == 0)
            ftr[$urandom_range(1, 3)] = payload_pick();
        foreach (ftr[i])
            send_byte(ftr[i]);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIM_W-1:0] v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------- tests

    // shortest frame right after reset reports the all-zero captures
    task automatic test_stale_captures();
        send_frame(0, 1'b1, 1'b0);
    endtask

    // a wrong header byte is not taken as a new first header byte
    task automatic test_header_slip();
        logic [7:0] seq [15];
        seq = '{rpfp_pkg::HDR_B1, rpfp_pkg::HDR_B2, rpfp_pkg::HDR_B1, rpfp_pkg::HDR_B2,
                rpfp_pkg::HDR_B3, rpfp_pkg::HDR_B4,
                rpfp_pkg::HDR_B1, rpfp_pkg::HDR_B1, rpfp_pkg::HDR_B2, rpfp_pkg::HDR_B3,
                rpfp_pkg::HDR_B4,
                rpfp_pkg::FTR_B1, rpfp_pkg::FTR_B2, rpfp_pkg::FTR_B3, rpfp_pkg::FTR_B4};
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    task automatic test_captures();
        logic [7:0] full_frame [21];
        logic [7:0] late_footer [17];
        full_frame = '{rpfp_pkg::HDR_B1, rpfp_pkg::HDR_B2, rpfp_pkg::HDR_B3, rpfp_pkg::HDR_B4,
                       8'h00, 8'h11, 8'h22, 8'h33, 8'h03, 8'h55, 8'h66,
                       8'hFF, 8'h88, 8'h99, 8'h00, 8'hFF, 8'hFF,
                       rpfp_pkg::FTR_B1, rpfp_pkg::FTR_B2, rpfp_pkg::FTR_B3, rpfp_pkg::FTR_B4};
        // footer bytes land on the static energy and distance indices
        late_footer = '{rpfp_pkg::HDR_B1, rpfp_pkg::HDR_B2, rpfp_pkg::HDR_B3, rpfp_pkg::HDR_B4,
                        8'h80, 8'h01, 8'h7F, 8'hFE, 8'h02, 8'h40, 8'h20, 8'h01, 8'h10,
                        rpfp_pkg::FTR_B1, rpfp_pkg::FTR_B2, rpfp_pkg::FTR_B3,
                        rpfp_pkg::FTR_B4};
        foreach (full_frame[i])
            send_byte(full_frame[i]);
        foreach (late_footer[i])
            send_byte(late_footer[i]);
    endtask

    // bodies around the limit, and an F8 run that drives the index to saturation
    task automatic test_limits();
        logic [LIM_W-1:0] lims [5];
        int unsigned      lim;
        lims = '{6'd13, 6'd63, 6'd0, 6'd12, 6'd1};
        foreach (lims[i])
        begin
            lim = lims[i];
            write_limit(lims[i]);
            send_frame((lim > 0) ? lim - 1 : 0, 1'b1, 1'b0);
            send_frame(lim, 1'b1, 1'b0);
            send_frame(lim + 1, 1'b1, 1'b0);
            send_frame(70, 1'b1, 1'b1);
            send_frame(0, 1'b1, 1'b0);
        end
    endtask

    task automatic test_backpressure();
        write_limit(rpfp_pkg::OVF_LIMIT_RESET);
        hold_asks++;
        steady = 1'b1;
        repeat (10)
            send_frame($urandom_range(0, 6), 1'b1, 1'b0);
        steady = 1'b0;
        // sender waits for every result before going on
        wait_idle();
        repeat (3)
            send_frame($urandom_range(5, 14), 1'b1, 1'b0);
    endtask

    task automatic test_random();
        int unsigned start_bytes;
        int unsigned phase_end;
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < 750)
        begin
            case ($urandom_range(0, 5))
                0:       write_limit(LIM_W'($urandom_range(0, 12)));
                1:       write_limit(rpfp_pkg::OVF_LIMIT_RESET);
                default: write_limit(LIM_W'($urandom_range(13, 63)));
            endcase
            steady = ($urandom_range(0, 3) == 0);
            phase_end = bytes_sent + 250;
            while (bytes_sent < phase_end)
            begin
                if ($urandom_range(0, 2) == 0)
                    send_noise($urandom_range(1, 4));
                if ($urandom_range(0, 9) == 0)
                    send_frame($urandom_range(13, 70), 1'b0, 1'b0);
                else
                    send_frame($urandom_range(0, 16), ($urandom_range(0, 2) == 0), 1'b0);
            end
        end
        steady = 1'b0;
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_stale_captures();
        test_header_slip();
        test_captures();
        test_limits();
        test_backpressure();
        test_random();
        wait_idle();
        repeat (8) @(posedge clk);
        if (reports_due.size() != 0)
        begin
            $error("%0d expected results never arrived", reports_due.size());
            errors++;
        end
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("tb: done, errors");
        $finish;
    end

endmodule
